[sv/brhm_pkg.sv]
// shared types and constants for the busy ratio history monitor
package brhm_pkg;

    // field widths
    localparam int COUNT_W = 64;
    localparam int TICK_W  = 32;
    localparam int LOAD_W  = 15;
    localparam int IVL_W   = 16;

    // 100 percent with 8 fractional bits
    localparam logic [LOAD_W-1:0] FULL_SCALE = 15'd25600;

    // scaled dividend width: 25600 * count fits in count plus quotient bits
    localparam int SCALED_W = COUNT_W + LOAD_W;

    // fixed history slots compared by the three reports
    localparam int SLOT_NEWEST    = 0;
    localparam int SLOT_PREVIOUS  = 1;
    localparam int SLOT_SPAN_HEAD = 2;
    localparam int SLOT_ONE_TAIL  = 3;
    localparam int SLOT_FIVE_TAIL = 7;

    // reset value of the interval register
    localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd1000;

    // register byte addresses
    localparam logic [2:0] ADDR_INTERVAL = 3'd0;

    // status returned by the ratio unit
    typedef struct packed {
        logic              done;
        logic              valid;
        logic [LOAD_W-1:0] load;
    } t_div_res;

endpackage

[sv/brhm_div.sv]
// ratio unit: floor(25600 * num / den) capped at 25600, one quotient bit per cycle
module brhm_div
    import brhm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COUNT_W-1:0] i_num,
    input  logic [COUNT_W-1:0] i_den,
    output t_div_res           o_res
);

    localparam int CNT_W = $clog2(LOAD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LOAD_W - 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_PREP,
        D_RUN
    } t_dstate;

    t_dstate            r_state;
    logic [COUNT_W-1:0] r_num;
    logic [COUNT_W-1:0] r_den;
    logic [COUNT_W-1:0] r_rem;
    logic [LOAD_W-1:0]  r_low;
    logic [LOAD_W-1:0]  r_quot;
    logic [CNT_W-1:0]   r_cnt;
    t_div_res           r_res;

    logic [SCALED_W-1:0] w_scaled;
    logic [COUNT_W:0]    w_trial;
    logic [COUNT_W:0]    w_diff;
    logic                w_fit;

    // 25600 = 2^14 + 2^13 + 2^10
    always_comb begin
        w_scaled = {1'b0, r_num, 14'b0} + {2'b0, r_num, 13'b0} + {5'b0, r_num, 10'b0};
    end

    // restoring step: bring down next dividend bit, compare and subtract
    always_comb begin
        w_trial = {r_rem, r_low[LOAD_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= D_IDLE;
            r_res.done <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_res.done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    // upper dividend bits are already below den: no quotient bits there
                    r_rem  <= w_scaled[SCALED_W-1:LOAD_W];
                    r_low  <= w_scaled[LOAD_W-1:0];
                    r_quot <= '0;
                    r_cnt  <= '0;
                    priority if (r_den == '0) begin
                        r_res.done  <= 1'b1;
                        r_res.valid <= 1'b0;
                        r_res.load  <= '0;
                        r_state     <= D_IDLE;
                    end else if (r_num >= r_den) begin
                        r_res.done  <= 1'b1;
                        r_res.valid <= 1'b1;
                        r_res.load  <= FULL_SCALE;
                        r_state     <= D_IDLE;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (w_fit) begin
                        r_rem <= w_diff[COUNT_W-1:0];
                    end else begin
                        r_rem <= w_trial[COUNT_W-1:0];
                    end
                    r_low  <= {r_low[LOAD_W-2:0], 1'b0};
                    r_quot <= {r_quot[LOAD_W-2:0], w_fit};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_res.done  <= 1'b1;
                        r_res.valid <= 1'b1;
                        r_res.load  <= {r_quot[LOAD_W-2:0], w_fit};
                        r_state     <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

[sv/busy_ratio_history_monitor.sv]
// top level: sample history store, report sequencer, stream and register ports
//
// channel   | direction | contents
// ----------+-----------+------------------------------------------------------
// s stream  | in        | one sample: busy, irq, idle counters and ms tick
// m stream  | out       | three busy percentages and their nonzero-span flags
// apb       | in/out    | min_interval_ms at byte address 0
//
// The history is updated at the accepting edge. Three ratios follow in turn, each
// with a select state, a prepare state, the quotient steps of the shared one-bit-per-cycle
// ratio unit and a state to take its result (a zero or saturated span skips the quotient
// steps); the output register is loaded last, and only then is a new sample accepted.
// Reset clears the history and sets the interval to 1000. The sequencer holds only if it
// finishes while a result waits.
module busy_ratio_history_monitor
    import brhm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // sample request
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [223:0] i_s_tdata,   // busy_time, irq_time, idle_time, tick_ms
    // result request
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,   // recent load, one second load, five second load, 3 zero bits
    output logic [2:0]   o_m_tuser,   // now_valid, one_sec_valid, five_sec_valid
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PASS_NOW,
        PASS_ONE,
        PASS_FIVE
    } t_pass;

    // history store
    logic [COUNT_W-1:0] r_snap_total [HISTORY_DEPTH];
    logic [COUNT_W-1:0] r_snap_busy  [HISTORY_DEPTH];
    logic [TICK_W-1:0]  r_snap_tick  [HISTORY_DEPTH];

    logic [IVL_W-1:0]  r_interval;
    t_state            r_state;
    t_pass             r_pass;
    logic [LOAD_W-1:0] r_share_now, r_load_one, r_load_five;
    logic              r_ok_now, r_ok_one, r_ok_five;
    logic              r_out_valid;
    logic [LOAD_W-1:0] r_out_now, r_out_one, r_out_five;
    logic [2:0]        r_out_flags;

    logic [COUNT_W-1:0] w_in_busy, w_in_irq, w_in_idle, w_in_total;
    logic [TICK_W-1:0]  w_in_tick, w_gap;
    logic               w_accept, w_shift, w_start;
    logic [COUNT_W-1:0] w_num, w_den;
    t_div_res           w_res;

    // unpack the sample
    assign w_in_busy  = i_s_tdata[63:0];
    assign w_in_irq   = i_s_tdata[127:64];
    assign w_in_idle  = i_s_tdata[191:128];
    assign w_in_tick  = i_s_tdata[223:192];
    assign w_in_total = w_in_busy + w_in_irq + w_in_idle;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // slot 1 after the update is the old newest slot
    assign w_gap   = r_snap_tick[SLOT_NEWEST] - r_snap_tick[SLOT_SPAN_HEAD];
    assign w_shift = (w_gap >= {{(TICK_W-IVL_W){1'b0}}, r_interval});

    // register port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_INTERVAL) begin
            prdata = {{(32-IVL_W){1'b0}}, r_interval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_INTERVAL)) begin
            r_interval <= pwdata[IVL_W-1:0];
        end
    end

    // history update on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_snap_total[i] <= '0;
                r_snap_busy[i]  <= '0;
                r_snap_tick[i]  <= '0;
            end
        end else if (w_accept) begin
            r_snap_total[SLOT_NEWEST]   <= w_in_total;
            r_snap_busy[SLOT_NEWEST]    <= w_in_busy;
            r_snap_tick[SLOT_NEWEST]    <= w_in_tick;
            r_snap_total[SLOT_PREVIOUS] <= r_snap_total[SLOT_NEWEST];
            r_snap_busy[SLOT_PREVIOUS]  <= r_snap_busy[SLOT_NEWEST];
            r_snap_tick[SLOT_PREVIOUS]  <= r_snap_tick[SLOT_NEWEST];
            if (w_shift) begin
                // slot 2 takes the sample that just moved into slot 1
                r_snap_total[SLOT_SPAN_HEAD] <= r_snap_total[SLOT_NEWEST];
                r_snap_busy[SLOT_SPAN_HEAD]  <= r_snap_busy[SLOT_NEWEST];
                r_snap_tick[SLOT_SPAN_HEAD]  <= r_snap_tick[SLOT_NEWEST];
                for (int i = SLOT_SPAN_HEAD + 1; i < HISTORY_DEPTH; i++) begin
                    r_snap_total[i] <= r_snap_total[i-1];
                    r_snap_busy[i]  <= r_snap_busy[i-1];
                    r_snap_tick[i]  <= r_snap_tick[i-1];
                end
            end
        end
    end

    // span operands for the current pass
    always_comb begin
        unique case (r_pass)
            PASS_NOW: begin
                w_num = r_snap_busy[SLOT_NEWEST] - r_snap_busy[SLOT_PREVIOUS];
                w_den = r_snap_total[SLOT_NEWEST] - r_snap_total[SLOT_PREVIOUS];
            end
            PASS_ONE: begin
                w_num = r_snap_busy[SLOT_SPAN_HEAD] - r_snap_busy[SLOT_ONE_TAIL];
                w_den = r_snap_total[SLOT_SPAN_HEAD] - r_snap_total[SLOT_ONE_TAIL];
            end
            default: begin
                w_num = r_snap_busy[SLOT_SPAN_HEAD] - r_snap_busy[SLOT_FIVE_TAIL];
                w_den = r_snap_total[SLOT_SPAN_HEAD] - r_snap_total[SLOT_FIVE_TAIL];
            end
        endcase
    end

    assign w_start = (r_state == S_LOAD);

    brhm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_res   (w_res)
    );

    // report sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= PASS_NOW;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pass  <= PASS_NOW;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_res.done) begin
                        unique case (r_pass)
                            PASS_NOW: begin
                                r_share_now <= w_res.load;
                                r_ok_now    <= w_res.valid;
                                r_pass      <= PASS_ONE;
                                r_state     <= S_LOAD;
                            end
                            PASS_ONE: begin
                                r_load_one <= w_res.load;
                                r_ok_one   <= w_res.valid;
                                r_pass     <= PASS_FIVE;
                                r_state    <= S_LOAD;
                            end
                            default: begin
                                r_load_five <= w_res.load;
                                r_ok_five   <= w_res.valid;
                                r_state     <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_now   <= r_share_now;
                        r_out_one   <= r_load_one;
                        r_out_five  <= r_load_five;
                        r_out_flags <= {r_ok_five, r_ok_one, r_ok_now};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_five, r_out_one, r_out_now};
    assign o_m_tuser  = r_out_flags;

endmodule

[sim/testbench.sv]
// self-checking testbench for the busy ratio history monitor
module testbench;
    import brhm_pkg::*;

    localparam int DEPTH        = 8;
    localparam int DRAIN_CYCLES = 60;

    // one sample request, busy counter in the lowest bits as on i_s_tdata
    typedef struct packed {
        logic [TICK_W-1:0]  tick;
        logic [COUNT_W-1:0] idle;
        logic [COUNT_W-1:0] irq;
        logic [COUNT_W-1:0] busy;
    } t_sample;

    // one result request as predicted
    typedef struct packed {
        logic [LOAD_W-1:0] recent_load;
        logic [LOAD_W-1:0] load_one_sec;
        logic [LOAD_W-1:0] load_five_sec;
        logic              now_ok;
        logic              one_sec_ok;
        logic              five_sec_ok;
    } t_report;

    typedef enum logic {
        READY_ALWAYS,
        READY_PATTERN
    } t_ready_mode;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [223:0] i_s_tdata;    // busy_time, irq_time, idle_time, tick_ms
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;    // recent load, one second load, five second load, 3 zero bits
    logic [2:0]   o_m_tuser;    // now_valid, one_sec_valid, five_sec_valid
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predicted history and interval register
    logic [COUNT_W-1:0] hist_total [DEPTH];
    logic [COUNT_W-1:0] hist_busy  [DEPTH];
    logic [TICK_W-1:0]  hist_tick  [DEPTH];
    logic [IVL_W-1:0]   interval_ms;

    t_report     pending_reports [$];
    int          error_count  = 0;
    t_sample     stream_pos;
    int          burst_left   = 0;
    int          gap_max      = 0;
    t_ready_mode ready_mode   = READY_ALWAYS;
    int          hold_request = 0;

    busy_ratio_history_monitor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // busy share of a span, 8 fractional bits, empty span flagged
    function automatic void busy_share(input logic [COUNT_W-1:0] dbusy,
                                       input logic [COUNT_W-1:0] dtotal,
                                       output logic [LOAD_W-1:0] load,
                                       output logic ok);
        logic [127:0] scaled;
        if (dtotal == '0) begin
            load = '0;
            ok   = 1'b0;
        end else if (dbusy >= dtotal) begin
            load = FULL_SCALE;
            ok   = 1'b1;
        end else begin
            scaled = ({64'b0, dbusy} * 128'(FULL_SCALE)) / {64'b0, dtotal};
            load   = scaled[LOAD_W-1:0];
            ok     = 1'b1;
        end
    endfunction

    // take one sample into the history and work out its report
    function automatic t_report advance_history(input t_sample s);
        t_report           r;
        logic [TICK_W-1:0] tick_gap;
        hist_total[SLOT_PREVIOUS] = hist_total[SLOT_NEWEST];
        hist_busy[SLOT_PREVIOUS]  = hist_busy[SLOT_NEWEST];
        hist_tick[SLOT_PREVIOUS]  = hist_tick[SLOT_NEWEST];
        hist_busy[SLOT_NEWEST]    = s.busy;
        hist_total[SLOT_NEWEST]   = s.busy + s.irq + s.idle;
        hist_tick[SLOT_NEWEST]    = s.tick;
        // keep a snapshot once the previous sample is far enough past the last one
        tick_gap = hist_tick[SLOT_PREVIOUS] - hist_tick[SLOT_SPAN_HEAD];
        if (tick_gap >= {16'b0, interval_ms}) begin
            for (int i = DEPTH - 1; i >= SLOT_SPAN_HEAD; i--) begin
                hist_total[i] = hist_total[i-1];
                hist_busy[i]  = hist_busy[i-1];
                hist_tick[i]  = hist_tick[i-1];
            end
        end
        busy_share(hist_busy[SLOT_NEWEST] - hist_busy[SLOT_PREVIOUS],
                   hist_total[SLOT_NEWEST] - hist_total[SLOT_PREVIOUS],
                   r.recent_load, r.now_ok);
        busy_share(hist_busy[SLOT_SPAN_HEAD] - hist_busy[SLOT_ONE_TAIL],
                   hist_total[SLOT_SPAN_HEAD] - hist_total[SLOT_ONE_TAIL],
                   r.load_one_sec, r.one_sec_ok);
        busy_share(hist_busy[SLOT_SPAN_HEAD] - hist_busy[SLOT_FIVE_TAIL],
                   hist_total[SLOT_SPAN_HEAD] - hist_total[SLOT_FIVE_TAIL],
                   r.load_five_sec, r.five_sec_ok);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [LOAD_W-1:0] want,
                                        input logic [LOAD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $error("result with no sample pending: tdata %h tuser %b",
                       o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("recent_load", want.recent_load, o_m_tdata[14:0]);
                check_field("load_one_sec", want.load_one_sec, o_m_tdata[29:15]);
                check_field("load_five_sec", want.load_five_sec, o_m_tdata[44:30]);
                check_field("now_valid", LOAD_W'(want.now_ok), LOAD_W'(o_m_tuser[0]));
                check_field("one_sec_valid", LOAD_W'(want.one_sec_ok),
                            LOAD_W'(o_m_tuser[1]));
                check_field("five_sec_valid", LOAD_W'(want.five_sec_ok),
                            LOAD_W'(o_m_tuser[2]));
            end
        end
    end

    // result side ready: steady, random runs, or a long hold when asked
    initial begin
        logic ready_now;
        int   run_left;
        ready_now = 1'b0;
        run_left  = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                run_left     = hold_request;
                hold_request = 0;
                ready_now    = 1'b0;
            end else if (run_left != 0) begin
                run_left--;
            end else if (ready_mode == READY_ALWAYS) begin
                ready_now = 1'b1;
            end else begin
                ready_now = !ready_now;
                run_left  = ready_now ? $urandom_range(0, 11) : $urandom_range(0, 7);
            end
            i_m_tready <= ready_now;
        end
    end

    // send one sample in bursts with random gaps, predict on acceptance
    task automatic offer_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        pending_reports.push_back(advance_history(s));
    endtask

    task automatic offer_counts(input logic [COUNT_W-1:0] busy, input logic [COUNT_W-1:0] irq,
                                input logic [COUNT_W-1:0] idle, input logic [TICK_W-1:0] tick);
        t_sample s;
        s.busy = busy;
        s.irq  = irq;
        s.idle = idle;
        s.tick = tick;
        offer_sample(s);
    endtask

    // wait until every result is back and the block has settled
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [IVL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_INTERVAL;
        pwdata  <= {16'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        interval_ms = value;
    endtask

    task automatic read_interval();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_INTERVAL;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata[IVL_W-1:0] !== interval_ms) begin
            $error("min_interval_ms mismatch: expected %0d, got %0d",
                   interval_ms, prdata[IVL_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly growing counters with random content, some jumps and frozen spans
    function automatic t_sample next_stream_sample();
        int                pick;
        logic [TICK_W-1:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            stream_pos.busy = {$urandom(), $urandom()};
            stream_pos.irq  = {$urandom(), $urandom()};
            stream_pos.idle = {$urandom(), $urandom()};
            stream_pos.tick = $urandom();
        end else if (pick < 13) begin
            // counters frozen: empty span
            stream_pos.tick += {16'b0, interval_ms};
        end else begin
            if ($urandom_range(0, 19) == 0)
                stream_pos.busy += {$urandom(), $urandom()};
            else
                stream_pos.busy += COUNT_W'($urandom_range(0, 1 << 20));
            stream_pos.irq += COUNT_W'($urandom_range(0, 1 << 12));
            if ($urandom_range(0, 3) != 0)
                stream_pos.idle += COUNT_W'($urandom_range(0, 1 << 20));
            case ($urandom_range(0, 3))
                0: step = {16'b0, interval_ms};
                1: step = {16'b0, interval_ms} - 32'd1;
                2: step = $urandom_range(0, 2 * interval_ms + 1);
                default: step = interval_ms / 4 + 1;
            endcase
            stream_pos.tick += step;
        end
        return stream_pos;
    endfunction

    // reset value, field extremes and the special spans
    task automatic test_directed();
        read_interval();
        ready_mode = READY_PATTERN;
        gap_max    = 3;
        offer_counts(64'd0, 64'd0, 64'd0, 32'd0);
        offer_counts(64'd1, 64'd0, 64'd1, 32'd500);
        offer_counts('1, 64'd0, 64'd0, 32'd1000);
        offer_counts('1, '1, '1, '1);
        // tick wraps back to zero
        offer_counts(64'd0, 64'd0, 64'd0, 32'd0);
        offer_counts(64'd10, 64'd50, 64'd40, 32'd1000);
        // busy grows more than the total
        offer_counts(64'd60, 64'd5, 64'd40, 32'd2000);
        // only busy grows: full scale
        offer_counts(64'd160, 64'd5, 64'd40, 32'd3000);
        // only idle grows: zero load
        offer_counts(64'd160, 64'd5, 64'd1040, 32'd4000);
        offer_counts(64'd160, 64'd5, 64'd1040, 32'd4000);
        offer_counts(64'd160, 64'h8000_0000_0000_0000, 64'd1040, 32'd4999);
        // fill the history with spans just under and over the interval
        for (int k = 0; k < 12; k++)
            offer_counts(64'd1000 + 300 * k, 64'h8000_0000_0000_0000 + 7 * k,
                         64'd2000 + 700 * k, 32'd5000 + 1000 * k - (k % 2));
        wait_idle();
    endtask

    // interval zero and the register limits
    task automatic test_interval_extremes();
        logic [IVL_W-1:0] extremes [3];
        extremes = '{16'd0, 16'd1, 16'hFFFF};
        ready_mode = READY_PATTERN;
        gap_max    = 4;
        stream_pos = '{$urandom(), {$urandom(), $urandom()}, {$urandom(), $urandom()},
                       {$urandom(), $urandom()}};
        foreach (extremes[n]) begin
            write_interval(extremes[n]);
            read_interval();
            repeat (40) offer_sample(next_stream_sample());
            wait_idle();
        end
    endtask

    // long result stall while samples keep coming, so the input backs up
    task automatic test_back_pressure();
        write_interval(IVL_W'($urandom_range(1, 200)));
        ready_mode   = READY_PATTERN;
        gap_max      = 0;
        hold_request = 300;
        repeat (30) offer_sample(next_stream_sample());
        wait_idle();
    endtask

    // random streams over several interval settings and idling styles
    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            write_interval(phase == 0 ? INTERVAL_RESET : IVL_W'($urandom_range(1, 3000)));
            ready_mode = (phase % 2 == 1) ? READY_ALWAYS : READY_PATTERN;
            gap_max    = (phase == 3) ? 0 : 6;
            repeat (100) offer_sample(next_stream_sample());
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= ADDR_INTERVAL;
        pwdata     <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            hist_total[i] = '0;
            hist_busy[i]  = '0;
            hist_tick[i]  = '0;
        end
        interval_ms = INTERVAL_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_interval_extremes();
        test_back_pressure();
        test_random();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // generous limit on the whole run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/brhm_pkg.sv
sv/brhm_div.sv
sv/busy_ratio_history_monitor.sv
sim/testbench.sv
